### rtl/core/rfo_pkg.sv
`timescale 1ns / 1ps
// Package of the rectangle rasterizer: payload structs, operation codes,
// register indexes, controller states and the command/status structs.
// Depends on nothing; every rtl/core module refers to it by scoped names.
package rfo_pkg;

  // Operation codes carried in the operation field
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_DRAW   = 2'd1,
    OP_READ   = 2'd2,
    OP_IGNORE = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_CANVAS_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_CANVAS_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_BACKGROUND_BYTE = 2'd2;

  localparam int CFG_DATA_W = 9;

  // Shape kind bytes
  localparam logic [7:0] KIND_FILLED  = 8'h52;
  localparam logic [7:0] KIND_OUTLINE = 8'h72;

  // Register reset values
  localparam logic [8:0] CANVAS_WIDTH_RST    = 9'd256;
  localparam logic [8:0] CANVAS_HEIGHT_RST   = 9'd256;
  localparam logic [7:0] BACKGROUND_BYTE_RST = 8'd32;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         shape_kind;
    logic signed [23:0] left_edge;
    logic signed [23:0] top_edge;
    logic signed [23:0] span_x;
    logic signed [23:0] span_y;
    logic [7:0]         paint_byte;
    logic [7:0]         read_column;
    logic [7:0]         read_row;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] pixel_byte;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic draw_ok;
    logic sweep_last;
  } dp_status_t;

endpackage

### rtl/core/rfo_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the rectangle rasterizer.
// Depends on rfo_pkg; drives the datapath through rfo_pkg::dp_cmd_t.
module rfo_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                out_free,
  input  rfo_pkg::dp_status_t status,
  output rfo_pkg::dp_cmd_t    cmd
);

  rfo_pkg::state_t state;
  rfo_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.out_load = 1'b0;
    in_stall     = 1'b1;
    unique case (state)
      rfo_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (status.op)
            rfo_pkg::OP_CLEAR:  state_next = rfo_pkg::ST_SWEEP;
            rfo_pkg::OP_DRAW:   state_next = status.draw_ok ? rfo_pkg::ST_SWEEP
                                                            : rfo_pkg::ST_EMIT;
            rfo_pkg::OP_READ:   state_next = rfo_pkg::ST_READ;
            rfo_pkg::OP_IGNORE: state_next = rfo_pkg::ST_EMIT;
            default:            state_next = rfo_pkg::ST_EMIT;
          endcase
        end
      end
      rfo_pkg::ST_SWEEP: begin
        cmd.step = 1'b1;
        if (status.sweep_last) begin
          state_next = rfo_pkg::ST_EMIT;
        end
      end
      rfo_pkg::ST_READ: begin
        // wait for the registered canvas read
        state_next = rfo_pkg::ST_EMIT;
      end
      rfo_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = rfo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rfo_pkg::ST_IDLE;
      end
    endcase
  end

  // A read beat always passes through the read wait state
  assert property (@(posedge clk) disable iff (rst)
    (state == rfo_pkg::ST_IDLE && in_valid && status.op == rfo_pkg::OP_READ)
      |=> state == rfo_pkg::ST_READ)
    else $error("read beat did not enter read wait");

  // A rejected rectangle never sweeps the canvas
  assert property (@(posedge clk) disable iff (rst)
    (state == rfo_pkg::ST_IDLE && in_valid && status.op == rfo_pkg::OP_DRAW &&
     !status.draw_ok) |=> state == rfo_pkg::ST_EMIT)
    else $error("invalid rectangle started a sweep");

  // The sweep ends on the last pixel
  assert property (@(posedge clk) disable iff (rst)
    (state == rfo_pkg::ST_SWEEP && status.sweep_last) |=> state == rfo_pkg::ST_EMIT)
    else $error("sweep overran last pixel");

  // A result is only loaded when the output slot is free
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free && !cmd.step && !cmd.load)
    else $error("result loaded into a busy slot");

endmodule

### rtl/core/rfo_datapath.sv
`timescale 1ns / 1ps
// Datapath of the rectangle rasterizer: configuration registers, item
// registers, pixel sweep counters, coverage test and the canvas memory.
// Depends on rfo_pkg; commanded by rfo_ctrl.
module rfo_datapath #(
  parameter int MAX_COLUMNS   = 256,
  parameter int MAX_ROWS      = 256,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [1:0]                          cfg_index,
  input  logic [rfo_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  rfo_pkg::in_item_t                   in_item,
  input  rfo_pkg::dp_cmd_t                    cmd,
  output rfo_pkg::dp_status_t                 status,
  output rfo_pkg::out_item_t                  result
);

  localparam int CB    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int XB    = (CB > RB) ? CB : RB;
  localparam int VW    = (XB + FRACTION_BITS + 2 > 27) ? XB + FRACTION_BITS + 2 : 27;
  localparam int AW    = CB + RB;
  localparam int DEPTH = 1 << AW;
  localparam logic signed [VW-1:0] One = VW'({1'b1, {FRACTION_BITS{1'b0}}});

  // Configuration registers
  logic [8:0] canvas_width;
  logic [8:0] canvas_height;
  logic [7:0] background_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= rfo_pkg::CANVAS_WIDTH_RST;
      canvas_height   <= rfo_pkg::CANVAS_HEIGHT_RST;
      background_byte <= rfo_pkg::BACKGROUND_BYTE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rfo_pkg::CFG_CANVAS_WIDTH:    canvas_width    <= cfg_data;
        rfo_pkg::CFG_CANVAS_HEIGHT:   canvas_height   <= cfg_data;
        rfo_pkg::CFG_BACKGROUND_BYTE: background_byte <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Last column and row in use, size clamped to 1..maximum
  logic [CB-1:0] col_last;
  logic [RB-1:0] row_last;

  always_comb begin
    if (canvas_width == 9'd0) begin
      col_last = '0;
    end else if (32'(canvas_width) > MAX_COLUMNS) begin
      col_last = CB'(MAX_COLUMNS - 1);
    end else begin
      col_last = CB'(canvas_width - 9'd1);
    end
    if (canvas_height == 9'd0) begin
      row_last = '0;
    end else if (32'(canvas_height) > MAX_ROWS) begin
      row_last = RB'(MAX_ROWS - 1);
    end else begin
      row_last = RB'(canvas_height - 9'd1);
    end
  end

  // Validate the incoming rectangle
  logic kind_ok;
  logic span_ok;

  assign kind_ok = (in_item.shape_kind == rfo_pkg::KIND_FILLED) ||
                   (in_item.shape_kind == rfo_pkg::KIND_OUTLINE);
  assign span_ok = !in_item.span_x[23] && (|in_item.span_x) &&
                   !in_item.span_y[23] && (|in_item.span_y);

  assign status.op      = rfo_pkg::op_t'(in_item.operation);
  assign status.draw_ok = kind_ok && span_ok;

  // Item registers
  rfo_pkg::op_t         op_r;
  logic                 reject_r;
  logic                 outline_r;
  logic [7:0]           paint_r;
  logic [CB-1:0]        rd_col_r;
  logic [RB-1:0]        rd_row_r;
  logic                 rd_in_r;
  logic signed [VW-1:0] left_r;
  logic signed [VW-1:0] right_r;
  logic signed [VW-1:0] top_r;
  logic signed [VW-1:0] bottom_r;
  logic signed [VW-1:0] left_in_r;
  logic signed [VW-1:0] right_in_r;
  logic signed [VW-1:0] top_in_r;
  logic signed [VW-1:0] bottom_in_r;
  logic signed [VW-1:0] right_sum;
  logic signed [VW-1:0] bottom_sum;

  assign right_sum  = VW'(in_item.left_edge) + VW'(in_item.span_x);
  assign bottom_sum = VW'(in_item.top_edge) + VW'(in_item.span_y);

  // Capture the beat and the edges, inner edges one unit inside
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= rfo_pkg::op_t'(in_item.operation);
      reject_r    <= (rfo_pkg::op_t'(in_item.operation) == rfo_pkg::OP_DRAW) &&
                     !(kind_ok && span_ok);
      outline_r   <= (in_item.shape_kind == rfo_pkg::KIND_OUTLINE);
      paint_r     <= in_item.paint_byte;
      rd_col_r    <= CB'(in_item.read_column);
      rd_row_r    <= RB'(in_item.read_row);
      rd_in_r     <= ((CB + 8)'(in_item.read_column) <= (CB + 8)'(col_last)) &&
                     ((RB + 8)'(in_item.read_row) <= (RB + 8)'(row_last));
      left_r      <= VW'(in_item.left_edge);
      top_r       <= VW'(in_item.top_edge);
      right_r     <= right_sum;
      bottom_r    <= bottom_sum;
      left_in_r   <= VW'(in_item.left_edge) + One;
      top_in_r    <= VW'(in_item.top_edge) + One;
      right_in_r  <= right_sum - One;
      bottom_in_r <= bottom_sum - One;
    end
  end

  // Sweep counters, row-major over the canvas in use
  logic [CB-1:0] x;
  logic [RB-1:0] y;
  logic          x_last;

  assign x_last            = (x == col_last);
  assign status.sweep_last = x_last && (y == row_last);

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      x <= '0;
      y <= '0;
    end else if (cmd.step) begin
      if (x_last) begin
        x <= '0;
        y <= y + RB'(1);
      end else begin
        x <= x + CB'(1);
      end
    end
  end

  // Coverage test of the current pixel
  logic signed [VW-1:0] px;
  logic signed [VW-1:0] py;
  logic                 in_x;
  logic                 in_y;
  logic                 on_edge;
  logic                 covered;

  assign px      = VW'({x, {FRACTION_BITS{1'b0}}});
  assign py      = VW'({y, {FRACTION_BITS{1'b0}}});
  assign in_x    = (px >= left_r) && (px <= right_r);
  assign in_y    = (py >= top_r) && (py <= bottom_r);
  assign on_edge = (px < left_in_r) || (px > right_in_r) ||
                   (py < top_in_r) || (py > bottom_in_r);
  assign covered = in_x && in_y && (!outline_r || on_edge);

  // Canvas memory, one write and one registered read port
  logic [7:0]    canvas_store [DEPTH];
  logic          mem_we;
  logic [7:0]    mem_wd;
  logic [7:0]    rd_data;

  assign mem_we = cmd.step && ((op_r == rfo_pkg::OP_CLEAR) || covered);
  assign mem_wd = (op_r == rfo_pkg::OP_CLEAR) ? background_byte : paint_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      canvas_store[{y, x}] <= mem_wd;
    end
    rd_data <= canvas_store[{rd_row_r, rd_col_r}];
  end

  // Result of the current item
  assign result.status     = reject_r;
  assign result.pixel_byte = ((op_r == rfo_pkg::OP_READ) && rd_in_r) ? rd_data : 8'd0;

endmodule

### rtl/core/rectangle_fill_outline_rasterizer.sv
`timescale 1ns / 1ps
// Clear and draw sweep the canvas in use one pixel a cycle through the single canvas
// write port; read passes a wait state for the registered memory read; a rejected
// rectangle or an ignored code has no sweep. One item is in work at a time;
// the next beat is taken once the result sits in the output register.
// Synchronous active-high reset clears control and the registers to 256, 256 and 32;
// the canvas has no clearing pass and holds undefined bytes until a clear.
module rectangle_fill_outline_rasterizer #(
  parameter int MAX_COLUMNS   = 256,
  parameter int MAX_ROWS      = 256,
  parameter int FRACTION_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [rfo_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rfo_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rfo_pkg::out_item_t             out_item
);

  rfo_pkg::dp_cmd_t    cmd;
  rfo_pkg::dp_status_t status;
  rfo_pkg::out_item_t  result;
  logic                out_free;

  assign out_free = !out_valid || !out_stall;

  rfo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  rfo_datapath #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_ROWS      (MAX_ROWS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  // Output register: load a result, drop it once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item <= result;
    end
  end

endmodule

### test/rfo_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the rectangle rasterizer: watches the register port and both beat channels.
// It keeps its own canvas and registers, predicts each answer and compares the result beats.
// Depends on rfo_pkg for the payload structs, operation codes and register indexes.
module rfo_raster_checker #(
  parameter int MAX_COLUMNS   = 256,
  parameter int MAX_ROWS      = 256,
  parameter int FRACTION_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [rfo_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  rfo_pkg::in_item_t              in_item,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  rfo_pkg::out_item_t             out_item,
  output int                             fail_count,
  output int                             pending_count
);

  logic [7:0]         canvas_px [MAX_COLUMNS*MAX_ROWS];
  logic [8:0]         width_reg;
  logic [8:0]         height_reg;
  logic [7:0]         bg_reg;
  rfo_pkg::out_item_t replies_q [$];
  rfo_pkg::out_item_t want;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Size register as the block uses it: zero acts as one, oversize as the maximum
  function automatic int unsigned used_extent(logic [8:0] v, int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // Apply one operation to the shadow canvas and return the answer it yields
  function automatic rfo_pkg::out_item_t rasterize(rfo_pkg::in_item_t it);
    rfo_pkg::out_item_t res;
    int unsigned        cols;
    int unsigned        rows;
    longint             unit;
    longint             lft;
    longint             tp;
    longint             span_w;
    longint             span_h;
    longint             rgt;
    longint             btm;
    longint             px;
    longint             py;
    bit                 filled;
    bit                 near_border;
    res    = '0;
    cols   = used_extent(width_reg, MAX_COLUMNS);
    rows   = used_extent(height_reg, MAX_ROWS);
    unit   = longint'(1) << FRACTION_BITS;
    case (rfo_pkg::op_t'(it.operation))
      rfo_pkg::OP_CLEAR: begin
        for (int y = 0; y < rows; y++)
          for (int x = 0; x < cols; x++)
            canvas_px[y*MAX_COLUMNS + x] = bg_reg;
      end
      rfo_pkg::OP_DRAW: begin
        lft    = $signed(it.left_edge);
        tp     = $signed(it.top_edge);
        span_w = $signed(it.span_x);
        span_h = $signed(it.span_y);
        rgt    = lft + span_w;
        btm    = tp + span_h;
        filled = (it.shape_kind == rfo_pkg::KIND_FILLED);
        if ((!filled && it.shape_kind != rfo_pkg::KIND_OUTLINE) || span_w <= 0 || span_h <= 0)
        begin
          res.status = 1'b1;
        end else begin
          for (int y = 0; y < rows; y++) begin
            py = longint'(y) * unit;
            if (py < tp || py > btm) continue;
            for (int x = 0; x < cols; x++) begin
              px = longint'(x) * unit;
              if (px < lft || px > rgt) continue;
              near_border = (px - lft < unit) || (rgt - px < unit) ||
                            (py - tp < unit) || (btm - py < unit);
              if (filled || near_border) canvas_px[y*MAX_COLUMNS + x] = it.paint_byte;
            end
          end
        end
      end
      rfo_pkg::OP_READ: begin
        if (it.read_column < cols && it.read_row < rows)
          res.pixel_byte = canvas_px[it.read_row*MAX_COLUMNS + it.read_column];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Track registers, compare result beats, then queue the answer for each input beat
  always @(posedge clk) begin
    if (rst) begin
      width_reg  = rfo_pkg::CANVAS_WIDTH_RST;
      height_reg = rfo_pkg::CANVAS_HEIGHT_RST;
      bg_reg     = rfo_pkg::BACKGROUND_BYTE_RST;
      replies_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          rfo_pkg::CFG_CANVAS_WIDTH:    width_reg  = cfg_data[8:0];
          rfo_pkg::CFG_CANVAS_HEIGHT:   height_reg = cfg_data[8:0];
          rfo_pkg::CFG_BACKGROUND_BYTE: bg_reg     = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (replies_q.size() == 0) begin
          fail_count++;
          $display("%0t: stray result beat: expected none, got status %0d pixel %02h",
                   $time, out_item.status, out_item.pixel_byte);
        end else begin
          want = replies_q.pop_front();
          if (out_item.status !== want.status || out_item.pixel_byte !== want.pixel_byte) begin
            fail_count++;
            $display("%0t: mismatch: expected status %0d pixel %02h, got status %0d pixel %02h",
                     $time, want.status, want.pixel_byte, out_item.status, out_item.pixel_byte);
          end
        end
      end
      if (in_valid && !in_stall) replies_q.push_back(rasterize(in_item));
    end
    pending_count = replies_q.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Top of the rasterizer testbench: clock, reset, register writes, stimulus and the verdict.
// Depends on rfo_pkg, the rasterizer RTL and rfo_raster_checker, which does all the comparing.
module tb_top;

  localparam int LIMIT_CYCLES    = 1_500_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int UNIT            = 256;

  logic                           clk;
  logic                           rst;
  logic                           cfg_write;
  logic [1:0]                     cfg_index;
  logic [rfo_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  rfo_pkg::in_item_t              in_item;
  logic                           out_valid;
  logic                           out_stall;
  rfo_pkg::out_item_t             out_item;
  int                             fail_count;
  int                             pending_count;
  int                             cycle_count;
  int                             send_idle_pct;
  int                             recv_stall_pct;
  int                             cur_cols;
  int                             cur_rows;
  int                             hold_cnt;
  bit                             hold_armed;
  bit                             hold_done;

  rectangle_fill_outline_rasterizer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  rfo_raster_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stall, plus one long hold-off once armed
  always @(negedge clk) begin
    if (hold_armed && !hold_done) begin
      out_stall = 1'b1;
      hold_cnt++;
      if (hold_cnt >= HOLD_OFF_CYCLES) hold_done = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic rfo_pkg::in_item_t rect_item(logic [7:0] kind, int l, int t,
                                                  int sx, int sy, logic [7:0] colour);
    rfo_pkg::in_item_t it;
    it            = '0;
    it.operation  = rfo_pkg::OP_DRAW;
    it.shape_kind = kind;
    it.left_edge  = l[23:0];
    it.top_edge   = t[23:0];
    it.span_x     = sx[23:0];
    it.span_y     = sy[23:0];
    it.paint_byte = colour;
    return it;
  endfunction

  function automatic rfo_pkg::in_item_t pixel_query(int c, int r);
    rfo_pkg::in_item_t it;
    it             = '0;
    it.operation   = rfo_pkg::OP_READ;
    it.read_column = c[7:0];
    it.read_row    = r[7:0];
    return it;
  endfunction

  function automatic rfo_pkg::in_item_t plain_op(rfo_pkg::op_t op);
    rfo_pkg::in_item_t it;
    it           = '0;
    it.operation = op;
    return it;
  endfunction

  // Mostly well-formed operations aimed at the canvas in use, some pure noise
  function automatic rfo_pkg::in_item_t random_op();
    rfo_pkg::in_item_t it;
    int                roll;
    it.operation   = 2'($urandom_range(3));
    it.shape_kind  = 8'($urandom);
    it.left_edge   = 24'($urandom);
    it.top_edge    = 24'($urandom);
    it.span_x      = 24'($urandom);
    it.span_y      = 24'($urandom);
    it.paint_byte  = 8'($urandom);
    it.read_column = 8'($urandom);
    it.read_row    = 8'($urandom);
    roll = int'($urandom_range(99));
    if (roll < 12) begin
      it.operation = rfo_pkg::OP_CLEAR;
    end else if (roll < 47) begin
      it.operation = rfo_pkg::OP_DRAW;
      if ($urandom_range(9) < 8) begin
        it.shape_kind = $urandom_range(1) ? rfo_pkg::KIND_FILLED : rfo_pkg::KIND_OUTLINE;
        it.left_edge  = 24'(int'($urandom_range((cur_cols + 4) * UNIT)) - 2 * UNIT);
        it.top_edge   = 24'(int'($urandom_range((cur_rows + 4) * UNIT)) - 2 * UNIT);
        it.span_x     = 24'($urandom_range((cur_cols + 2) * UNIT, 1));
        it.span_y     = 24'($urandom_range((cur_rows + 2) * UNIT, 1));
      end
    end else if (roll < 92) begin
      it.operation = rfo_pkg::OP_READ;
      if ($urandom_range(99) < 85) begin
        it.read_column = 8'($urandom_range(cur_cols - 1));
        it.read_row    = 8'($urandom_range(cur_rows - 1));
      end
    end else if (roll < 96) begin
      it.operation = rfo_pkg::OP_IGNORE;
    end
    return it;
  endfunction

  // Offer one beat, idling beforehand at the phase's rate, and hold it until taken
  task automatic send_beat(input rfo_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_item  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic run_random(input int n);
    int                sent;
    rfo_pkg::in_item_t it;
    sent = 0;
    while (sent < n) begin
      it = random_op();
      send_beat(it);
      if (it.operation != rfo_pkg::OP_IGNORE) sent++;
    end
  endtask

  // Drop valid and wait until every answer is in, then let the block settle
  task automatic drain();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    cfg_index = idx;
    cfg_data  = val[rfo_pkg::CFG_DATA_W-1:0];
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_canvas(input int w, input int h, input int bg);
    drain();
    write_reg(rfo_pkg::CFG_CANVAS_WIDTH, w);
    write_reg(rfo_pkg::CFG_CANVAS_HEIGHT, h);
    write_reg(rfo_pkg::CFG_BACKGROUND_BYTE, bg);
    cur_cols = (w == 0) ? 1 : ((w > 256) ? 256 : w);
    cur_rows = (h == 0) ? 1 : ((h > 256) ? 256 : h);
  endtask

  initial begin
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_item        = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_armed     = 1'b0;
    hold_done      = 1'b0;
    hold_cnt       = 0;
    cur_cols       = 256;
    cur_rows       = 256;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Fill the whole store once at reset size so no pixel is ever read unwritten
    send_beat(plain_op(rfo_pkg::OP_CLEAR));

    // Directed: shapes, fractions, rejects, wide sums and reads outside the canvas
    set_canvas(20, 20, 8'h00);
    send_beat(plain_op(rfo_pkg::OP_CLEAR));
    send_beat(rect_item(rfo_pkg::KIND_FILLED, 2*UNIT, 3*UNIT, 5*UNIT, 4*UNIT, 8'h11));
    send_beat(rect_item(rfo_pkg::KIND_OUTLINE, 9*UNIT + 128, UNIT + 64, 8*UNIT + 192,
                        10*UNIT + 128, 8'hEE));
    send_beat(pixel_query(4, 5));
    send_beat(pixel_query(13, 6));
    send_beat(pixel_query(10, 6));
    send_beat(pixel_query(19, 19));
    send_beat(pixel_query(20, 5));
    send_beat(pixel_query(255, 255));
    send_beat(rect_item(8'h00, 0, 0, UNIT, UNIT, 8'h33));
    send_beat(rect_item(8'hFF, 0, 0, UNIT, UNIT, 8'h33));
    send_beat(rect_item(rfo_pkg::KIND_FILLED, 0, 0, 0, UNIT, 8'h44));
    send_beat(rect_item(rfo_pkg::KIND_OUTLINE, 0, 0, UNIT, -1, 8'h44));
    send_beat(rect_item(rfo_pkg::KIND_FILLED, 0, 0, -8388608, UNIT, 8'h44));
    send_beat(rect_item(rfo_pkg::KIND_FILLED, -8388608, -8388608, 8388607, 8388607, 8'h55));
    send_beat(rect_item(rfo_pkg::KIND_OUTLINE, 8388607, 8388607, 8388607, 8388607, 8'h66));
    send_beat(rect_item(rfo_pkg::KIND_FILLED, -UNIT, -UNIT, 8388607, 8388607, 8'hFF));
    send_beat(pixel_query(0, 0));
    send_beat(rect_item(rfo_pkg::KIND_OUTLINE, 0, 0, 19*UNIT, 19*UNIT, 8'h00));
    send_beat(pixel_query(0, 10));
    send_beat(pixel_query(10, 10));
    send_beat(plain_op(rfo_pkg::OP_IGNORE));
    send_beat(pixel_query(19, 0));

    // Sender idling, zero width acts as one column, oversize height as full
    send_idle_pct = 66;
    set_canvas(0, 511, 8'hFF);
    run_random(10);

    // Receiver stalling, oversize width, single row
    send_idle_pct  = 0;
    recv_stall_pct = 66;
    set_canvas(511, 1, 8'h5A);
    run_random(10);

    // Both sides idling now and then
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    set_canvas($urandom_range(24, 1), $urandom_range(24, 1), $urandom_range(255));
    run_random(25);

    // Long receiver hold-off while beats keep coming, so the input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_canvas(8, 8, 8'hC3);
    hold_armed = 1'b1;
    run_random(15);

    // Smallest canvas, zero height acts as one row
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    set_canvas(1, 0, 8'h01);
    run_random(5);

    // Full-size canvas: one sweep only, then reads across it
    set_canvas(256, 256, $urandom_range(255));
    send_beat(rect_item(rfo_pkg::KIND_OUTLINE, 10*UNIT + 128, 20*UNIT, 200*UNIT, 230*UNIT,
                        8'($urandom_range(255))));
    send_beat(pixel_query(11, 100));
    send_beat(pixel_query(100, 100));
    send_beat(pixel_query(210, 250));
    send_beat(pixel_query(255, 255));

    // Closing random stretch without idling
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_canvas($urandom_range(32, 1), $urandom_range(32, 1), $urandom_range(255));
    run_random(15);

    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rfo_pkg.sv
rtl/core/rfo_ctrl.sv
rtl/core/rfo_datapath.sv
rtl/core/rectangle_fill_outline_rasterizer.sv
test/rfo_checker.sv
test/tb_top.sv
